// ----- rtl/core/wbss_pkg.sv -----
package wbss_pkg;

  localparam int SIG_BYTES = 16;
  localparam int SIG_IDX_BITS = 4;
  localparam int LEN_BITS = 7;
  localparam int ADDR_BITS = 6;
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_BITS = 3;
  localparam int DATA_BITS = 64;
  localparam int LEN_REG_BITS = 5;
  localparam int MASK_REG_BITS = 16;

  localparam logic [REG_IDX_BITS-1:0] REG_BASE_ADDRESS   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_SIGNATURE_LOW  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_SIGNATURE_HIGH = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_CARE_MASK      = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_SIGNATURE_LEN  = 3'd4;

  localparam logic [MASK_REG_BITS-1:0] CARE_MASK_RESET = 16'hffff;
  localparam logic [LEN_REG_BITS-1:0] SIGNATURE_LEN_RESET = 5'd1;

  typedef struct packed {
    logic [63:0] base_address;
    logic [63:0] signature_low;
    logic [63:0] signature_high;
    logic [MASK_REG_BITS-1:0] care_mask;
    logic [LEN_REG_BITS-1:0] signature_length;
  } cfg_t;

  typedef struct packed {
    logic [SIG_BYTES-1:0][7:0] signature;
    logic [SIG_BYTES-1:0] care;
    logic [LEN_BITS-1:0] len_used;
  } sig_cfg_t;

  typedef struct packed {
    logic found;
    logic [63:0] match_address;
  } result_t;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

// ----- rtl/core/wbss_if.sv -----
interface wbss_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbss_out_if;
  logic valid;
  logic ready;
  logic found;
  logic [63:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink (input valid, input found, input match_address, output ready);
endinterface

// ----- rtl/core/wbss_cell.sv -----
module wbss_cell #(
  parameter int POS = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic shift_en,
  input  logic flush,
  input  logic [7:0] byte_in,
  input  logic valid_in,
  input  wbss_pkg::sig_cfg_t sig_cfg,
  output logic [7:0] byte_q,
  output logic valid_q,
  output logic ok
);

  logic [wbss_pkg::LEN_BITS-1:0] sig_idx;
  logic active;
  logic in_range;
  logic must_match;
  logic [7:0] sig_byte;

  always_comb begin
    active = sig_cfg.len_used > wbss_pkg::LEN_BITS'(POS);
    sig_idx = sig_cfg.len_used - wbss_pkg::LEN_BITS'(POS) - wbss_pkg::LEN_BITS'(1);
    in_range = sig_idx < wbss_pkg::LEN_BITS'(wbss_pkg::SIG_BYTES);
    sig_byte = sig_cfg.signature[sig_idx[wbss_pkg::SIG_IDX_BITS-1:0]];
    must_match = in_range && sig_cfg.care[sig_idx[wbss_pkg::SIG_IDX_BITS-1:0]];
    ok = !active || (valid_in && (!must_match || (byte_in == sig_byte)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (shift_en) begin
      valid_q <= flush ? 1'b0 : valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= byte_in;
    end
  end

endmodule

// ----- rtl/core/wbss_regs.sv -----
module wbss_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [wbss_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wbss_pkg::DATA_BITS-1:0] pwdata,
  output logic [wbss_pkg::DATA_BITS-1:0] prdata,
  output logic pready,
  output wbss_pkg::cfg_t cfg
);

  logic [wbss_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[wbss_pkg::ADDR_BITS-1:wbss_pkg::REG_IDX_LSB];
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= '0;
      cfg.signature_low <= '0;
      cfg.signature_high <= '0;
      cfg.care_mask <= wbss_pkg::CARE_MASK_RESET;
      cfg.signature_length <= wbss_pkg::SIGNATURE_LEN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        wbss_pkg::REG_BASE_ADDRESS: cfg.base_address <= pwdata;
        wbss_pkg::REG_SIGNATURE_LOW: cfg.signature_low <= pwdata;
        wbss_pkg::REG_SIGNATURE_HIGH: cfg.signature_high <= pwdata;
        wbss_pkg::REG_CARE_MASK: cfg.care_mask <= pwdata[wbss_pkg::MASK_REG_BITS-1:0];
        wbss_pkg::REG_SIGNATURE_LEN: begin
          cfg.signature_length <= pwdata[wbss_pkg::LEN_REG_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wbss_pkg::REG_BASE_ADDRESS: prdata = cfg.base_address;
      wbss_pkg::REG_SIGNATURE_LOW: prdata = cfg.signature_low;
      wbss_pkg::REG_SIGNATURE_HIGH: prdata = cfg.signature_high;
      wbss_pkg::REG_CARE_MASK: prdata = wbss_pkg::DATA_BITS'(cfg.care_mask);
      wbss_pkg::REG_SIGNATURE_LEN: prdata = wbss_pkg::DATA_BITS'(cfg.signature_length);
      default: prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/wbss_out_buf.sv -----
module wbss_out_buf (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  wbss_pkg::result_t push_data,
  output logic can_push,
  output wbss_pkg::buf_status_t status,
  wbss_out_if.source out_ch
);

  logic out_valid;
  logic skid_valid;
  wbss_pkg::result_t out_data;
  wbss_pkg::result_t skid_data;
  logic out_free;

  assign can_push = !skid_valid;
  assign out_free = !out_valid || out_ch.ready;
  assign status.out_valid = out_valid;
  assign status.skid_valid = skid_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.found = out_data.found;
  assign out_ch.match_address = out_data.match_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- rtl/core/wildcard_byte_signature_scan_unit.sv -----
// Channel    Role    Payload                        Beat taken when
// scan_in    sink    data_byte[7:0], last_byte      valid && ready
// scan_out   source  found, match_address[63:0]    valid && ready
// APB        slave   64-bit registers at 8*index    psel && penable && pwrite
//
// One byte is taken every cycle while ready is high; a result is registered in the
// output buffer before it appears on scan_out. The rate is set by the row of window
// cells, which shift and compare all signature positions in parallel in the same cycle.
// Reset is synchronous; it clears the window and offset count and resets the registers.
// Results wait in a two-entry output buffer; scan_in drops ready only while both
// entries are full.
module wildcard_byte_signature_scan_unit #(
  parameter int MAX_SIGNATURE = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [wbss_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wbss_pkg::DATA_BITS-1:0] pwdata,
  output logic [wbss_pkg::DATA_BITS-1:0] prdata,
  output logic pready,
  wbss_in_if.sink scan_in,
  wbss_out_if.source scan_out
);

  wbss_pkg::cfg_t cfg;
  wbss_pkg::sig_cfg_t sig_cfg;
  wbss_pkg::result_t result;
  wbss_pkg::buf_status_t buf_status;
  logic [wbss_pkg::LEN_BITS-1:0] len_raw;
  logic [wbss_pkg::LEN_BITS-1:0] len_m1;
  logic [MAX_SIGNATURE-1:0][7:0] win_byte;
  logic [MAX_SIGNATURE-1:0] win_valid;
  logic [MAX_SIGNATURE-1:0] cell_ok;
  logic [COUNT_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0] offset;
  logic reported;
  logic accept;
  logic hit;
  logic push;
  logic can_push;

  wbss_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  always_comb begin
    len_raw = wbss_pkg::LEN_BITS'(cfg.signature_length);
    sig_cfg.signature = {cfg.signature_high, cfg.signature_low};
    sig_cfg.care = cfg.care_mask;
    if (len_raw == '0) begin
      sig_cfg.len_used = wbss_pkg::LEN_BITS'(1);
    end else if (len_raw > wbss_pkg::LEN_BITS'(MAX_SIGNATURE)) begin
      sig_cfg.len_used = wbss_pkg::LEN_BITS'(MAX_SIGNATURE);
    end else begin
      sig_cfg.len_used = len_raw;
    end
    len_m1 = sig_cfg.len_used - wbss_pkg::LEN_BITS'(1);
  end

  assign accept = scan_in.valid && scan_in.ready;
  assign scan_in.ready = can_push;

  for (genvar p = 0; p < MAX_SIGNATURE; p++) begin : g_cell
    if (p == 0) begin : g_head
      wbss_cell #(.POS(p)) u_cell (
        .clk(clk), .rst(rst), .shift_en(accept), .flush(scan_in.last_byte),
        .byte_in(scan_in.data_byte), .valid_in(1'b1), .sig_cfg(sig_cfg),
        .byte_q(win_byte[p]), .valid_q(win_valid[p]), .ok(cell_ok[p])
      );
    end else begin : g_body
      wbss_cell #(.POS(p)) u_cell (
        .clk(clk), .rst(rst), .shift_en(accept), .flush(scan_in.last_byte),
        .byte_in(win_byte[p-1]), .valid_in(win_valid[p-1]), .sig_cfg(sig_cfg),
        .byte_q(win_byte[p]), .valid_q(win_valid[p]), .ok(cell_ok[p])
      );
    end
  end

  assign hit = !reported && (&cell_ok);
  assign offset = bytes_seen - COUNT_BITS'(len_m1);
  assign push = accept && !reported && ((&cell_ok) || scan_in.last_byte);

  always_comb begin
    result.found = hit;
    result.match_address = hit ? cfg.base_address + 64'(offset) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      reported <= 1'b0;
    end else if (accept) begin
      if (scan_in.last_byte) begin
        bytes_seen <= '0;
        reported <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen + COUNT_BITS'(1);
        reported <= reported || hit;
      end
    end
  end

  wbss_out_buf u_out_buf (
    .clk(clk), .rst(rst), .push(push), .push_data(result), .can_push(can_push),
    .status(buf_status), .out_ch(scan_out)
  );

  a_hit_marks_reported: assert property (@(posedge clk) disable iff (rst)
    (accept && !scan_in.last_byte && hit) |=> reported)
    else $error("hit did not set the reported flag");

  a_region_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && scan_in.last_byte) |=> (bytes_seen == '0 && !reported && win_valid == '0))
    else $error("region end did not clear the scan state");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    buf_status.skid_valid |-> buf_status.out_valid)
    else $error("skid entry held while output register empty");

endmodule
